// ----- rtl/lpi_pkg.sv -----
package lpi_pkg;

    localparam int CW = 32;
    localparam int FW = 16;
    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int NW = PW + 1;
    localparam int MW = NW + EW;
    localparam int DW = MW + 2;
    localparam int UW = DW + EW;
    localparam int QW = CW + 1;
    localparam int RIW = 3;
    localparam int SW = 34;
    localparam int LPW = SW + 1 + EW;
    localparam int HPW = NW - SW + EW;

    localparam logic [RIW-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [RIW-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [RIW-1:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [RIW-1:0] REG_THROUGH_X = 3'd3;
    localparam logic [RIW-1:0] REG_THROUGH_Y = 3'd4;
    localparam logic [RIW-1:0] REG_THROUGH_Z = 3'd5;

    localparam logic [1:0] KIND_POINT    = 2'd0;
    localparam logic [1:0] KIND_IN_PLANE = 2'd1;
    localparam logic [1:0] KIND_PARALLEL = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] vert_a_x;
        logic signed [CW-1:0] vert_a_y;
        logic signed [CW-1:0] vert_a_z;
        logic signed [CW-1:0] vert_b_x;
        logic signed [CW-1:0] vert_b_y;
        logic signed [CW-1:0] vert_b_z;
        logic signed [CW-1:0] vert_c_x;
        logic signed [CW-1:0] vert_c_y;
        logic signed [CW-1:0] vert_c_z;
    } tri_word_t;

    typedef struct packed {
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
        logic signed [CW-1:0] hit_z;
        logic [1:0]           hit_kind;
    } hit_word_t;

endpackage

// ----- rtl/lpi_plane.sv -----
module lpi_plane
    import lpi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid,
    input  tri_word_t            tri_word,
    input  logic signed [CW-1:0] org [3],
    input  logic signed [EW-1:0] dir [3],
    output logic                 plane_valid,
    output logic signed [DW-1:0] d_val,
    output logic signed [DW-1:0] e_val
);

    logic signed [CW-1:0] va [3];
    logic signed [CW-1:0] vb [3];
    logic signed [CW-1:0] vc [3];

    logic signed [EW-1:0]  ab_reg  [3];
    logic signed [EW-1:0]  ac_reg  [3];
    logic signed [EW-1:0]  ap1_reg [3];
    logic signed [EW-1:0]  ap2_reg [3];
    logic signed [EW-1:0]  ap3_reg [3];
    logic signed [PW-1:0]  pr_reg  [6];
    logic signed [NW-1:0]  n_reg   [3];
    logic signed [LPW-1:0] mlo_reg [3];
    logic signed [HPW-1:0] mhi_reg [3];
    logic signed [LPW-1:0] flo_reg [3];
    logic signed [HPW-1:0] fhi_reg [3];
    logic signed [MW-1:0]  m_reg   [3];
    logic signed [MW-1:0]  f_reg   [3];
    logic signed [DW-1:0]  d_reg;
    logic signed [DW-1:0]  e_reg;
    logic [5:0]            v_reg;

    assign va[0] = tri_word.vert_a_x;
    assign va[1] = tri_word.vert_a_y;
    assign va[2] = tri_word.vert_a_z;
    assign vb[0] = tri_word.vert_b_x;
    assign vb[1] = tri_word.vert_b_y;
    assign vb[2] = tri_word.vert_b_z;
    assign vc[0] = tri_word.vert_c_x;
    assign vc[1] = tri_word.vert_c_y;
    assign vc[2] = tri_word.vert_c_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ab_reg[i]  <= EW'(vb[i]) - EW'(va[i]);
                ac_reg[i]  <= EW'(vc[i]) - EW'(va[i]);
                ap1_reg[i] <= EW'(va[i]) - EW'(org[i]);
                ap2_reg[i] <= ap1_reg[i];
                ap3_reg[i] <= ap2_reg[i];
            end
            pr_reg[0] <= ab_reg[1] * ac_reg[2];
            pr_reg[1] <= ab_reg[2] * ac_reg[1];
            pr_reg[2] <= ab_reg[2] * ac_reg[0];
            pr_reg[3] <= ab_reg[0] * ac_reg[2];
            pr_reg[4] <= ab_reg[0] * ac_reg[1];
            pr_reg[5] <= ab_reg[1] * ac_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i]   <= NW'(pr_reg[2*i]) - NW'(pr_reg[2*i+1]);
                mlo_reg[i] <= $signed({1'b0, n_reg[i][SW-1:0]}) * ap3_reg[i];
                mhi_reg[i] <= $signed(n_reg[i][NW-1:SW]) * ap3_reg[i];
                flo_reg[i] <= $signed({1'b0, n_reg[i][SW-1:0]}) * dir[i];
                fhi_reg[i] <= $signed(n_reg[i][NW-1:SW]) * dir[i];
                m_reg[i]   <= (MW'(mhi_reg[i]) <<< SW) + MW'(mlo_reg[i]);
                f_reg[i]   <= (MW'(fhi_reg[i]) <<< SW) + MW'(flo_reg[i]);
            end
            d_reg <= DW'(m_reg[0]) + DW'(m_reg[1]) + DW'(m_reg[2]);
            e_reg <= DW'(f_reg[0]) + DW'(f_reg[1]) + DW'(f_reg[2]);
        end
    end

    assign plane_valid = v_reg[5];
    assign d_val       = d_reg;
    assign e_val       = e_reg;

endmodule

// ----- rtl/lpi_divide.sv -----
module lpi_divide
    import lpi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid,
    input  logic signed [DW-1:0] d_val,
    input  logic signed [DW-1:0] e_val,
    input  logic signed [CW-1:0] org [3],
    input  logic signed [EW-1:0] dir [3],
    output logic                 hit_valid,
    output hit_word_t            hit_word
);

    localparam logic signed [CW+2:0] SAT_HI = (CW+3)'((64'sd1 <<< (CW-1)) - 1);
    localparam logic signed [CW+2:0] SAT_LO = -(CW+3)'(64'sd1 <<< (CW-1));

    logic signed [LPW-1:0] pp_reg [3][3];
    logic signed [DW-1:0]  ep_reg;
    logic                  ezp_reg;
    logic                  dzp_reg;
    logic                  vp_reg;

    logic signed [UW-1:0] num_reg [3];
    logic signed [DW-1:0] e6_reg;
    logic                 ez6_reg;
    logic                 dz6_reg;
    logic                 v6_reg;

    logic [UW-1:0] rem_reg [QW+1][3];
    logic [QW-1:0] quo_reg [QW+1][3];
    logic [DW-1:0] den_reg [QW+1];
    logic [2:0]    neg_reg [QW+1];
    logic [2:0]    ovf_reg [QW+1];
    logic [1:0]    kind_reg [QW+1];
    logic          v_reg [QW+1];

    logic signed [CW+2:0] qs [3];
    logic signed [CW+2:0] sum [3];
    logic signed [CW-1:0] res [3];

    hit_word_t out_reg;
    logic      out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            v6_reg <= 1'b0;
            for (int s = 0; s <= QW; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg   <= valid;
            v6_reg   <= vp_reg;
            v_reg[0] <= v6_reg;
            for (int s = 1; s <= QW; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            out_v_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pp_reg[i][0] <= $signed({1'b0, d_val[SW-1:0]}) * dir[i];
                pp_reg[i][1] <= $signed({1'b0, d_val[2*SW-1:SW]}) * dir[i];
                pp_reg[i][2] <= $signed(d_val[DW-1:2*SW]) * dir[i];
            end
            ep_reg  <= e_val;
            ezp_reg <= (e_val == '0);
            dzp_reg <= (d_val == '0);

            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= (UW'(pp_reg[i][2]) <<< (2*SW)) + (UW'(pp_reg[i][1]) <<< SW)
                              + UW'(pp_reg[i][0]);
            end
            e6_reg  <= ep_reg;
            ez6_reg <= ezp_reg;
            dz6_reg <= dzp_reg;

            den_reg[0] <= e6_reg[DW-1] ? DW'(-e6_reg) : DW'(e6_reg);
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= num_reg[i][UW-1] ? UW'(-num_reg[i]) : UW'(num_reg[i]);
                quo_reg[0][i] <= '0;
                neg_reg[0][i] <= num_reg[i][UW-1] ^ e6_reg[DW-1];
                ovf_reg[0][i] <= (num_reg[i][UW-1] ? UW'(-num_reg[i]) : UW'(num_reg[i]))
                                 >= {(e6_reg[DW-1] ? DW'(-e6_reg) : DW'(e6_reg)),
                                     {QW{1'b0}}};
            end
            if (!ez6_reg)
            begin
                kind_reg[0] <= KIND_POINT;
            end
            else if (dz6_reg)
            begin
                kind_reg[0] <= KIND_IN_PLANE;
            end
            else
            begin
                kind_reg[0] <= KIND_PARALLEL;
            end

            for (int s = 1; s <= QW; s++)
            begin
                den_reg[s]  <= den_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                kind_reg[s] <= kind_reg[s-1];
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[s-1][i] >= (UW'(den_reg[s-1]) << (QW - s)))
                    begin
                        rem_reg[s][i] <= rem_reg[s-1][i] - (UW'(den_reg[s-1]) << (QW - s));
                        quo_reg[s][i] <= quo_reg[s-1][i] | (QW'(1) << (QW - s));
                    end
                    else
                    begin
                        rem_reg[s][i] <= rem_reg[s-1][i];
                        quo_reg[s][i] <= quo_reg[s-1][i];
                    end
                end
            end

            out_reg.hit_kind <= kind_reg[QW];
            unique case (kind_reg[QW])
                KIND_POINT:
                begin
                    out_reg.hit_x <= res[0];
                    out_reg.hit_y <= res[1];
                    out_reg.hit_z <= res[2];
                end
                KIND_IN_PLANE:
                begin
                    out_reg.hit_x <= org[0];
                    out_reg.hit_y <= org[1];
                    out_reg.hit_z <= org[2];
                end
                default:
                begin
                    out_reg.hit_x <= '0;
                    out_reg.hit_y <= '0;
                    out_reg.hit_z <= '0;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qs[i]  = neg_reg[QW][i] ? -$signed({2'b00, quo_reg[QW][i]})
                                    : $signed({2'b00, quo_reg[QW][i]});
            sum[i] = (CW+3)'(org[i]) + qs[i];
            if (ovf_reg[QW][i])
            begin
                res[i] = neg_reg[QW][i] ? CW'(SAT_LO) : CW'(SAT_HI);
            end
            else if (sum[i] > SAT_HI)
            begin
                res[i] = CW'(SAT_HI);
            end
            else if (sum[i] < SAT_LO)
            begin
                res[i] = CW'(SAT_LO);
            end
            else
            begin
                res[i] = sum[i][CW-1:0];
            end
        end
    end

    assign hit_valid = out_v_reg;
    assign hit_word  = out_reg;

endmodule

// ----- rtl/line_plane_intersection_top.sv -----
// Intersects the line through the configured points origin and through with the plane of
// each triangle word in signed fixed point, and returns the hit point with a kind code:
// a single point, the line lying in the plane (the origin is returned), or a parallel
// line (zeros). One triangle word is taken in every cycle while no result is stalled,
// and each result passes through nine stages of products, sums and sign handling, then
// the 33-stage quotient pipeline, one quotient bit per stage, then an output register.
// A stalled result stalls the whole pipeline.
// The line points may be written only while no triangle is in flight.
module line_plane_intersection_top
    import lpi_pkg::*;
#(
    parameter int FRAC_BITS = FW
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tri_valid,
    output logic           tri_ready,
    input  tri_word_t      tri_word,
    output logic           hit_valid,
    input  logic           hit_ready,
    output hit_word_t      hit_word,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [RIW-1:0] cfg_index,
    input  logic [CW-1:0]  cfg_data
);

    logic signed [CW-1:0] org_reg [3];
    logic signed [CW-1:0] thr_reg [3];
    logic signed [EW-1:0] dir [3];
    logic                 en;
    logic                 plane_valid;
    logic signed [DW-1:0] d_val;
    logic signed [DW-1:0] e_val;

    assign cfg_ready = 1'b1;
    assign en        = !hit_valid || hit_ready;
    assign tri_ready = en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dir[i] = EW'(thr_reg[i]) - EW'(org_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            thr_reg[0] <= '0;
            thr_reg[1] <= '0;
            thr_reg[2] <= CW'(64'd1 << FRAC_BITS);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:  org_reg[0] <= cfg_data;
                REG_ORIGIN_Y:  org_reg[1] <= cfg_data;
                REG_ORIGIN_Z:  org_reg[2] <= cfg_data;
                REG_THROUGH_X: thr_reg[0] <= cfg_data;
                REG_THROUGH_Y: thr_reg[1] <= cfg_data;
                REG_THROUGH_Z: thr_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    lpi_plane u_plane (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .valid       (tri_valid),
        .tri_word    (tri_word),
        .org         (org_reg),
        .dir         (dir),
        .plane_valid (plane_valid),
        .d_val       (d_val),
        .e_val       (e_val)
    );

    lpi_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (plane_valid),
        .d_val     (d_val),
        .e_val     (e_val),
        .org       (org_reg),
        .dir       (dir),
        .hit_valid (hit_valid),
        .hit_word  (hit_word)
    );

    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && hit_word.hit_kind == KIND_PARALLEL
        |-> hit_word.hit_x == '0 && hit_word.hit_y == '0 && hit_word.hit_z == '0)
        else $error("parallel result carries a nonzero point");

    a_in_plane_origin: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && hit_word.hit_kind == KIND_IN_PLANE
        |-> hit_word.hit_x == org_reg[0] && hit_word.hit_y == org_reg[1]
            && hit_word.hit_z == org_reg[2])
        else $error("in-plane result differs from the origin");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_ready |-> !tri_ready)
        else $error("triangle taken while a result is stalled");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid |-> hit_word.hit_kind != 2'd3)
        else $error("result kind has no meaning");

endmodule
